[rtl/core/mlmr_pkg.sv]
// Shared types, codes and CRC helpers for the level monitor / Modbus responder.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package mlmr_pkg;

  // input item modes
  localparam logic [1:0] MODE_SAMPLE    = 2'd0;
  localparam logic [1:0] MODE_BYTE      = 2'd1;
  localparam logic [1:0] MODE_FRAME_END = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [1:0] CFG_CONFIRM    = 2'd2;

  localparam logic [7:0] RST_SLAVE_ADDR = 8'd1;
  localparam logic [9:0] RST_THRESHOLD  = 10'd500;
  localparam logic [7:0] RST_CONFIRM    = 8'd10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [3:0]  CHECK_BYTES = 4'd6;  // request bytes covered by its CRC
  localparam logic [3:0]  RESP_DATA   = 4'd7;  // response bytes before its CRC
  localparam logic [3:0]  RESP_LEN    = 4'd9;
  localparam logic [7:0]  BYTE_COUNT  = 8'd4;
  localparam logic [15:0] REQ_LEN     = 16'd2;

  // controller -> datapath
  typedef struct packed {
    logic       capture;   // latch the input beat
    logic       apply;     // apply the latched item to state
    logic       crc_init;
    logic       crc_step;
    logic       crc_resp;  // CRC byte source: 1 response byte, 0 frame buffer
    logic       load_out;
    logic [1:0] out_kind;
    logic       out_last;
    logic [3:0] idx;
  } mlmr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       frame_ok;
    logic       out_free;
  } mlmr_sts_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] resp_byte(input logic [2:0] idx,
                                           input logic [7:0] addr,
                                           input logic [7:0] func,
                                           input logic [7:0] flags,
                                           input logic [7:0] sw);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = addr;
      3'd1:    b = func;
      3'd2:    b = BYTE_COUNT;
      3'd4:    b = flags;
      3'd6:    b = sw;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mlmr_datapath.sv]
// Datapath: config registers, confirm counters, flags, frame buffer, CRC and
// the output register. Depends on mlmr_pkg; driven by mlmr_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module mlmr_datapath import mlmr_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int FRAME_BYTES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_wdata,
  input  wire logic [1:0] in_mode,
  input  wire logic [2:0] in_channel,
  input  wire logic [9:0] in_sample,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [7:0] in_switch_status,
  input  wire logic       out_stall,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_tx_byte,
  output logic [7:0]      out_level_flags,
  output logic            out_last,
  input  wire mlmr_cmd_t  cmd,
  output mlmr_sts_t       sts
);

  localparam int BW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int FW = $clog2(FRAME_BYTES + 1);

  logic [7:0] addr_r, confirm_r;
  logic [9:0] thresh_r;

  logic [1:0] mode_r;
  logic [2:0] chan_r;
  logic [9:0] sample_r;
  logic [7:0] rx_r, sw_r;

  logic [7:0] cnt_r [CHANNELS];
  logic [7:0] cnt_nxt [CHANNELS];
  logic [7:0] flags_r, flags_nxt;
  logic [7:0] buf_r [FRAME_BYTES];
  logic [FW-1:0] fill_r;
  logic [15:0] crc_r;

  logic       out_valid_r, out_last_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_tx_r, out_flags_r;

  logic [7:0]  crc_src, rsp_b, tx_sel, cnt_inc;
  logic [BW-1:0] rd_idx;

  assign rd_idx = cmd.idx[BW-1:0];
  assign rsp_b  = resp_byte(cmd.idx[2:0], addr_r, buf_r[1], flags_r, sw_r);
  assign crc_src = cmd.crc_resp ? rsp_b : buf_r[rd_idx];

  always_comb begin
    if (cmd.out_kind != KIND_RESP) tx_sel = 8'd0;
    else if (cmd.idx < RESP_DATA) tx_sel = rsp_b;
    else if (cmd.idx == RESP_DATA) tx_sel = crc_r[7:0];
    else tx_sel = crc_r[15:8];
  end

  // sample update, only one channel matches
  always_comb begin
    flags_nxt = flags_r;
    cnt_inc   = 8'd0;
    for (int c = 0; c < CHANNELS; c++) begin
      cnt_nxt[c] = cnt_r[c];
      if (chan_r == 3'(c)) begin
        if (sample_r > thresh_r) begin
          cnt_inc = cnt_r[c] + 8'd1;
          if (cnt_inc > confirm_r) begin
            cnt_nxt[c]   = 8'd0;
            flags_nxt[c] = 1'b1;
          end else begin
            cnt_nxt[c] = cnt_inc;
          end
        end else begin
          cnt_nxt[c]   = 8'd0;
          flags_nxt[c] = 1'b0;
        end
      end
    end
  end

  assign sts.mode     = mode_r;
  assign sts.frame_ok = (buf_r[0] == addr_r) && ({buf_r[7], buf_r[6]} == crc_r) &&
                        ({buf_r[4], buf_r[5]} == REQ_LEN);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= RST_SLAVE_ADDR;
      thresh_r    <= RST_THRESHOLD;
      confirm_r   <= RST_CONFIRM;
      flags_r     <= 8'd0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) cnt_r[c] <= 8'd0;
      for (int i = 0; i < FRAME_BYTES; i++) buf_r[i] <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLAVE_ADDR: addr_r    <= cfg_wdata[7:0];
          CFG_THRESHOLD:  thresh_r  <= cfg_wdata;
          CFG_CONFIRM:    confirm_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (cmd.apply) begin
        unique case (mode_r)
          MODE_SAMPLE: begin
            flags_r <= flags_nxt;
            for (int c = 0; c < CHANNELS; c++) cnt_r[c] <= cnt_nxt[c];
          end
          MODE_BYTE: begin
            if (fill_r < FW'(FRAME_BYTES)) begin
              buf_r[fill_r[BW-1:0]] <= rx_r;
              fill_r <= fill_r + FW'(1);
            end
          end
          MODE_FRAME_END: fill_r <= '0;
          default: ;
        endcase
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload, CRC and output data registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      chan_r   <= in_channel;
      sample_r <= in_sample;
      rx_r     <= in_rx_byte;
      sw_r     <= in_switch_status;
    end
    if (cmd.crc_init) crc_r <= CRC_INIT;
    else if (cmd.crc_step) crc_r <= crc16_byte(crc_r, crc_src);
    if (cmd.load_out) begin
      out_kind_r  <= cmd.out_kind;
      out_tx_r    <= tx_sel;
      out_flags_r <= flags_r;
      out_last_r  <= cmd.out_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_tx_byte     = out_tx_r;
  assign out_level_flags = out_flags_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

[rtl/core/mlmr_ctrl.sv]
// Controller: sequences sample/byte updates, frame CRC check and the response.
// Depends on mlmr_pkg; drives mlmr_datapath through mlmr_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module mlmr_ctrl import mlmr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire mlmr_sts_t sts,
  output mlmr_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CHK, S_DECIDE, S_RSP, S_SEND, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;

  // no beat is taken while reset is held
  assign in_stall = !rst_n || (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.idx      = idx_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.apply = 1'b1;
        if (sts.mode == MODE_FRAME_END) begin
          cmd.crc_init = 1'b1;
          idx_nxt      = 4'd0;
          state_nxt    = S_CHK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_CHK: begin
        cmd.crc_step = 1'b1;
        idx_nxt      = idx_r + 4'd1;
        if (idx_r == CHECK_BYTES - 4'd1) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.frame_ok) begin
          cmd.crc_init = 1'b1;
          idx_nxt      = 4'd0;
          state_nxt    = S_RSP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_RSP: begin
        cmd.crc_step = 1'b1;
        cmd.crc_resp = 1'b1;
        cmd.out_kind = KIND_RESP;
        if (idx_r == RESP_DATA - 4'd1) begin
          idx_nxt   = 4'd0;
          state_nxt = S_SEND;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      S_SEND: begin
        cmd.out_kind = KIND_RESP;
        cmd.out_last = (idx_r == RESP_LEN - 4'd1);
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          idx_nxt      = idx_r + 4'd1;
          if (cmd.out_last) state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd.out_kind = (sts.mode == MODE_FRAME_END) ? KIND_REJECT : KIND_REPORT;
        cmd.out_last = 1'b1;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/modbus_level_monitor_responder_core.sv]
// Eight-channel level monitor with a Modbus RTU read responder.
// Input beats carry a mode: ADC sample (channel, sample), received serial byte,
// or end of frame (with the switch status byte for the reply). A sample updates
// the channel's confirm counter and flag; a byte fills the frame buffer.
// Results: a status report per sample, byte or other non-frame-end beat; at
// frame end nine response bytes (kind 1, last on the ninth) or a single reject.
// Timing: one item in flight at a time. A sample or byte beat is captured, then
// applied in the execute state and loaded into the output register by the emit
// state, which waits while the output is held; then the next beat is taken.
// A frame end walks the six request bytes through the CRC one byte per cycle;
// if the frame is accepted, the response CRC over seven bytes follows, then the
// nine bytes are emitted one per cycle while the output is not held.
// The output register holds a finished result while the next beat is accepted.
// Out_stall holds the output beat and, once a further result is ready, the
// controller waits; in_stall is high while an item is being worked.
// Reset (rst_n low, synchronous) restores config to address 1, threshold 500,
// confirm count 10, and clears counters, flags and frame buffer. Config writes
// (cfg_we) act on the next edge; the user must make them while idle, unchecked.
`timescale 1ns / 1ps
`default_nettype none

module modbus_level_monitor_responder_core import mlmr_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int FRAME_BYTES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_mode,
  input  wire logic [2:0] in_channel,
  input  wire logic [9:0] in_sample,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [7:0] in_switch_status,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_tx_byte,
  output logic [7:0]      out_level_flags,
  output logic            out_last
);

  mlmr_cmd_t cmd;
  mlmr_sts_t sts;

  mlmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlmr_datapath #(
    .CHANNELS    (CHANNELS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_channel       (in_channel),
    .in_sample        (in_sample),
    .in_rx_byte       (in_rx_byte),
    .in_switch_status (in_switch_status),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_level_flags  (out_level_flags),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

  // an accepted beat keeps the input side busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again right after a beat");

  // a pending stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register loaded while held");

  // reports and rejects are single-beat results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_RESP) |-> out_last)
    else $error("single result without last");

  // CRC stepping and output loading never overlap
  a_crc_vs_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.crc_step |-> !cmd.load_out)
    else $error("CRC step during output load");

endmodule

`default_nettype wire

[bench/mlmr_response_checker.sv]
// Bench package (Modbus CRC, no-op mode code) and the response checker.
// The checker watches the config port and both channels of the core, predicts every result
// beat and compares it with what the core sends. Depends on mlmr_pkg.
`timescale 1ns / 1ps

package mlmr_bench_pkg;

  localparam logic [1:0]  MODE_NOP        = 2'd3;
  localparam logic [15:0] MODBUS_CRC_SEED = 16'hFFFF;
  localparam logic [15:0] MODBUS_CRC_POLY = 16'hA001;

  // one byte of the reflected Modbus CRC-16
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                  input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) acc = {1'b0, acc[15:1]} ^ (acc[0] ? MODBUS_CRC_POLY : 16'h0000);
    return acc;
  endfunction

endpackage

module mlmr_response_checker import mlmr_pkg::*, mlmr_bench_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_wdata,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [1:0] in_mode,
  input  wire logic [2:0] in_channel,
  input  wire logic [9:0] in_sample,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [7:0] in_switch_status,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] out_kind,
  input  wire logic [7:0] out_tx_byte,
  input  wire logic [7:0] out_level_flags,
  input  wire logic       out_last,
  output int unsigned     results_due,
  output int unsigned     mismatches
);

  typedef struct {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] flags;
    logic       last;
  } result_beat_t;

  result_beat_t owed_results[$];

  logic [7:0]  reg_addr;
  logic [9:0]  reg_thr;
  logic [7:0]  reg_confirm;
  logic [7:0]  confirm_cnt [8];
  logic [7:0]  level_flags;
  logic [7:0]  rx_frame [8];
  int unsigned frame_fill;

  task automatic owe_result(input logic [1:0] kind, input logic [7:0] tx, input logic last);
    owed_results.push_back('{kind, tx, level_flags, last});
  endtask

  task automatic step_responder(input logic [1:0] mode, input logic [2:0] ch,
                                input logic [9:0] smp, input logic [7:0] rxb,
                                input logic [7:0] sw);
    logic [15:0] crc;
    logic [7:0]  reply [9];
    if (mode == MODE_FRAME_END) begin
      frame_fill = 0;
      crc = MODBUS_CRC_SEED;
      for (int i = 0; i < 6; i++) crc = modbus_crc_byte(crc, rx_frame[i]);
      if (rx_frame[0] != reg_addr || {rx_frame[7], rx_frame[6]} != crc ||
          {rx_frame[4], rx_frame[5]} != 16'd2) begin
        owe_result(KIND_REJECT, 8'h00, 1'b1);
      end else begin
        // read reply: addr, function, byte count 4, flags word, switch word, CRC lo/hi
        reply[0] = reg_addr;
        reply[1] = rx_frame[1];
        reply[2] = 8'd4;
        reply[3] = 8'h00;
        reply[4] = level_flags;
        reply[5] = 8'h00;
        reply[6] = sw;
        crc = MODBUS_CRC_SEED;
        for (int i = 0; i < 7; i++) crc = modbus_crc_byte(crc, reply[i]);
        reply[7] = crc[7:0];
        reply[8] = crc[15:8];
        for (int i = 0; i < 9; i++) owe_result(KIND_RESP, reply[i], i == 8);
      end
    end else begin
      if (mode == MODE_SAMPLE) begin
        if (smp > reg_thr) begin
          confirm_cnt[ch] = confirm_cnt[ch] + 8'd1;  // 8-bit, wraps
          if (confirm_cnt[ch] > reg_confirm) begin
            level_flags[ch] = 1'b1;
            confirm_cnt[ch] = 8'h00;
          end
        end else begin
          confirm_cnt[ch] = 8'h00;
          level_flags[ch] = 1'b0;
        end
      end else if (mode == MODE_BYTE && frame_fill < 8) begin
        rx_frame[frame_fill] = rxb;
        frame_fill++;
      end
      owe_result(KIND_REPORT, 8'h00, 1'b1);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_beat_t want;
    if (!rst_n) begin
      reg_addr    = 8'd1;
      reg_thr     = 10'd500;
      reg_confirm = 8'd10;
      level_flags = 8'h00;
      frame_fill  = 0;
      for (int i = 0; i < 8; i++) begin
        confirm_cnt[i] = 8'h00;
        rx_frame[i]    = 8'h00;
      end
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ADDR: reg_addr    = cfg_wdata[7:0];
          CFG_THRESHOLD:  reg_thr     = cfg_wdata;
          CFG_CONFIRM:    reg_confirm = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // compare before predicting: a beat leaving now never belongs to the item entering now
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result beat with none outstanding: kind %0d tx 0x%0h flags 0x%0h last %0b",
                 out_kind, out_tx_byte, out_level_flags, out_last);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_kind));
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("level_flags", want.flags, out_level_flags);
          check_field("last", 8'(want.last), 8'(out_last));
        end
      end
      if (in_valid && !in_stall)
        step_responder(in_mode, in_channel, in_sample, in_rx_byte, in_switch_status);
    end
    results_due <= owed_results.size();
  end

endmodule

[bench/tb_modbus_level_monitor_responder_core.sv]
// Top of the level monitor / Modbus responder bench: clock, reset, stimulus, verdict.
// Instantiates modbus_level_monitor_responder_core and mlmr_response_checker;
// depends on mlmr_pkg and mlmr_bench_pkg.
`timescale 1ns / 1ps

module tb_modbus_level_monitor_responder_core;
  import mlmr_pkg::*;
  import mlmr_bench_pkg::*;

  localparam int IDLE_LIMIT    = 4000;  // cycles with no beat on either channel
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 150;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SLAVE_ADDR;
  logic [9:0] cfg_wdata = 10'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode = MODE_SAMPLE;
  logic [2:0] in_channel = 3'd0;
  logic [9:0] in_sample = 10'd0;
  logic [7:0] in_rx_byte = 8'd0;
  logic [7:0] in_switch_status = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_tx_byte;
  logic [7:0] out_level_flags;
  logic       out_last;

  int unsigned results_due;
  int unsigned mismatches;

  int send_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int beats_sent = 0;

  logic [7:0] cur_addr = 8'd1;
  logic [9:0] cur_thr = 10'd500;

  always #6 clk = ~clk;

  modbus_level_monitor_responder_core dut (.*);

  mlmr_response_checker chk (.*);

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_modbus_level_monitor_responder_core failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [1:0] mode, input logic [2:0] ch, input logic [9:0] smp,
                           input logic [7:0] rxb, input logic [7:0] sw);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_channel       <= ch;
    in_sample        <= smp;
    in_rx_byte       <= rxb;
    in_switch_status <= sw;
    do begin
      @(posedge clk);
      taken = in_valid && !in_stall;
    end while (!taken);
    beats_sent++;
  endtask

  task automatic send_sample(input logic [2:0] ch, input logic [9:0] smp);
    send_beat(MODE_SAMPLE, ch, smp, 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [9:0] wet_sample();
    return (cur_thr == 10'd1023) ? 10'd1023 : 10'($urandom_range(1023, int'(cur_thr) + 1));
  endfunction

  // request frame: addr, function, start, length, CRC; keep trims it (stale tail),
  // extra appends random bytes after the kept ones, corrupt flips one bit anywhere
  task automatic send_request(input logic [7:0] addr, input logic [7:0] func,
                              input logic [15:0] start, input logic [15:0] len,
                              input int keep, input int extra, input bit corrupt,
                              input logic [7:0] sw);
    logic [7:0]  req [8];
    logic [15:0] crc;
    int          pos;
    req[0] = addr;
    req[1] = func;
    req[2] = start[15:8];
    req[3] = start[7:0];
    req[4] = len[15:8];
    req[5] = len[7:0];
    crc = MODBUS_CRC_SEED;
    for (int i = 0; i < 6; i++) crc = modbus_crc_byte(crc, req[i]);
    req[6] = crc[7:0];
    req[7] = crc[15:8];
    if (corrupt) begin
      pos = $urandom_range(7);
      req[pos][$urandom_range(7)] ^= 1'b1;
    end
    for (int i = 0; i < keep + extra; i++)
      send_beat(MODE_BYTE, 3'($urandom), 10'($urandom),
                (i < keep) ? req[i] : 8'($urandom), 8'($urandom));
    send_beat(MODE_FRAME_END, 3'($urandom), 10'($urandom), 8'($urandom), sw);
  endtask

  task automatic random_traffic(input int n);
    int         stop_at;
    int         pick;
    logic [2:0] ch;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_request(($urandom_range(99) < 85) ? cur_addr : 8'($urandom),
                     8'($urandom), 16'($urandom),
                     ($urandom_range(99) < 85) ? 16'd2 : 16'($urandom),
                     ($urandom_range(99) < 85) ? 8 : $urandom_range(7),
                     ($urandom_range(99) < 10) ? $urandom_range(3, 1) : 0,
                     $urandom_range(99) < 15, 8'($urandom));
      end else if (pick < 85) begin
        // a run on one channel, mostly wet, so flags get set and cleared
        ch = 3'($urandom);
        repeat ($urandom_range(6, 1))
          send_sample(ch, ($urandom_range(99) < 75) ? wet_sample()
                                                    : 10'($urandom_range(cur_thr)));
      end else begin
        send_beat(2'($urandom), 3'($urandom), 10'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // wait for every owed result to leave before touching the config port
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] addr, input logic [9:0] thr,
                              input logic [7:0] confirm);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDR;
    cfg_wdata <= {2'b00, addr};
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= CFG_CONFIRM;
    cfg_wdata <= {2'b00, confirm};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_addr = addr;
    cur_thr  = thr;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 19;
    rx_idle_pct <= 55;
    @(posedge clk);

    // directed, reset register values
    send_sample(3'd0, 10'd1023);
    send_sample(3'd7, 10'd0);
    send_sample(3'd3, 10'd500);  // equal to threshold is dry
    send_sample(3'd3, 10'd501);
    send_beat(MODE_NOP, 3'd7, 10'd1023, 8'hFF, 8'hFF);
    send_request(8'd1, 8'h03, 16'h00FF, 16'd2, 8, 2, 1'b0, 8'hFF);  // overflow dropped
    send_request(8'd1, 8'h03, 16'h00FF, 16'd2, 2, 0, 1'b0, 8'h00);  // stale tail passes
    send_request(8'h00, 8'h00, 16'h0000, 16'd2, 1, 0, 1'b0, 8'h5A); // wrong address
    wait_idle();

    program_regs(8'd247, 10'd0, 8'd0);
    random_traffic(20);
    wait_idle();

    send_idle_pct = 55;
    rx_idle_pct <= 19;
    program_regs(8'd0, 10'd1023, 8'd3);
    random_traffic(10);
    hold_token <= hold_token + 1;  // long receiver hold while beats keep coming
    random_traffic(15);
    wait_idle();

    send_idle_pct = 0;
    rx_idle_pct <= 0;
    program_regs(8'($urandom_range(246, 1)), 10'($urandom_range(800, 200)), 8'd2);
    random_traffic(20);
    wait_idle();

    // confirm count 255: a short wet run never passes it, flag stays clear
    program_regs(cur_addr, 10'd0, 8'd255);
    send_sample(3'd5, 10'd0);
    repeat (4) send_sample(3'd5, 10'($urandom_range(1023, 1)));
    wait_idle();
    program_regs(cur_addr, 10'd0, 8'd1);
    send_sample(3'd5, 10'd1023);  // counter 5, above 1: flag sets
    send_request(cur_addr, 8'h04, 16'($urandom), 16'd2, 8, 0, 1'b0, 8'($urandom));
    wait_idle();

    if (mismatches == 0 && results_due == 0)
      $display("tb_modbus_level_monitor_responder_core passed");
    else
      $display("tb_modbus_level_monitor_responder_core failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/mlmr_pkg.sv
rtl/core/mlmr_datapath.sv
rtl/core/mlmr_ctrl.sv
rtl/core/modbus_level_monitor_responder_core.sv
bench/mlmr_response_checker.sv
bench/tb_modbus_level_monitor_responder_core.sv
